// File: rtl/bvpe_pkg.sv
//------------------------------------------------------------------------------
// Bitmap video pixel expander package
// Shared types, codes, palette and frame-length tables for the expander.
//------------------------------------------------------------------------------
`default_nettype none

package bvpe_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIDEO_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEM_MODE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISP_CTL   = 2'd2;

   // Register reset values
   localparam logic [5:0] VIDEO_BASE_RST = 6'd2;

   // Memory controller mode that selects DMA
   localparam logic [2:0] SAM_DMA = 3'd7;

   // Graphics mode codes
   localparam logic [2:0] GM_1C = 3'd0;
   localparam logic [2:0] GM_1R = 3'd1;
   localparam logic [2:0] GM_2C = 3'd2;
   localparam logic [2:0] GM_2R = 3'd3;
   localparam logic [2:0] GM_3C = 3'd4;
   localparam logic [2:0] GM_3R = 3'd5;
   localparam logic [2:0] GM_6C = 3'd6;
   localparam logic [2:0] GM_6R = 3'd7;
   localparam logic [3:0] GM_NONE = 4'd8;

   // Default depth of the request queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // One classified request as handed from front to back
   typedef struct packed {
      logic [7:0]  video_byte;
      logic [15:0] byte_address;
      logic [2:0]  mode;
      logic        unsup;
      logic        css;
      logic        frame_end;
   } desc_type;

   // 8-entry palette, index = pixel + 4 * colour set
   function automatic logic [3:0] palette_lookup(input logic [2:0] idx);
      logic [3:0] c;
      unique case (idx)
         3'd0:    c = 4'd10;
         3'd1:    c = 4'd14;
         3'd2:    c = 4'd9;
         3'd3:    c = 4'd12;
         3'd4:    c = 4'd15;
         3'd5:    c = 4'd3;
         3'd6:    c = 4'd13;
         default: c = 4'd6;
      endcase
      return c;
   endfunction

   // Frame length in bytes for each graphics mode
   function automatic logic [12:0] frame_len(input logic [2:0] mode);
      logic [12:0] n;
      unique case (mode)
         GM_1C, GM_1R: n = 13'd1024;
         GM_2C:        n = 13'd2048;
         GM_2R:        n = 13'd1536;
         GM_3C, GM_3R: n = 13'd3072;
         default:      n = 13'd6144;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bvpe_if.sv
//------------------------------------------------------------------------------
// Bitmap video pixel expander channels
// Valid/ready interfaces for the byte request channel and the pixel channel.
//------------------------------------------------------------------------------
`default_nettype none

interface bvpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] video_byte;

   modport source  (output valid, output video_byte, input ready);
   modport sink    (input valid, input video_byte, output ready);
   modport monitor (input valid, input video_byte, input ready);
endinterface

interface bvpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  pixel_color;
   logic [15:0] byte_address;
   logic [3:0]  graphics_mode;
   logic        unsupported;
   logic        last_of_byte;
   logic        last_of_frame;

   modport source (output valid, output pixel_color, output byte_address,
                   output graphics_mode, output unsupported, output last_of_byte,
                   output last_of_frame, input ready);
   modport sink   (input valid, input pixel_color, input byte_address,
                   input graphics_mode, input unsupported, input last_of_byte,
                   input last_of_frame, output ready);
   modport monitor (input valid, input pixel_color, input byte_address,
                    input graphics_mode, input unsupported, input last_of_byte,
                    input last_of_frame, input ready);
endinterface

`default_nettype wire

// File: rtl/bvpe_front.sv
//------------------------------------------------------------------------------
// Bitmap video pixel expander front end
// Holds the mode registers and byte counter, classifies each request and
// pushes a descriptor into the queue.
//------------------------------------------------------------------------------
`default_nettype none

module bvpe_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wr_en,
   input  wire  [bvpe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [bvpe_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  wire                                  req_valid,
   input  wire  [7:0]                           req_video_byte,
   output logic                                 req_ready,
   input  wire                                  q_full,
   output logic                                 q_push,
   output bvpe_pkg::desc_type                   q_push_data
);
   import bvpe_pkg::*;

   logic [5:0]  video_base_ff, video_base_in;
   logic [2:0]  mem_mode_ff, mem_mode_in;
   logic [4:0]  disp_ctl_ff, disp_ctl_in;
   logic [12:0] byte_counter_ff, byte_counter_in;

   logic        unsup;
   logic [2:0]  mode;
   logic        frame_end;
   logic [13:0] count_next;

   // Register writes
   always_comb begin
      video_base_in = video_base_ff;
      mem_mode_in   = mem_mode_ff;
      disp_ctl_in   = disp_ctl_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VIDEO_BASE: video_base_in = csr_wr_data;
            CSR_MEM_MODE:   mem_mode_in   = csr_wr_data[2:0];
            CSR_DISP_CTL:   disp_ctl_in   = csr_wr_data[4:0];
            default:        ;
         endcase
      end
   end

   // Mode decode and frame position
   always_comb begin
      unsup      = (mem_mode_ff == SAM_DMA) || !disp_ctl_ff[4];
      mode       = disp_ctl_ff[3:1];
      count_next = {1'b0, byte_counter_ff} + 14'd1;
      frame_end  = count_next >= {1'b0, frame_len(mode)};
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      q_push_data.video_byte   = req_video_byte;
      q_push_data.byte_address = {1'b0, video_base_ff, 9'd0} + {3'd0, byte_counter_ff};
      q_push_data.mode         = mode;
      q_push_data.unsup        = unsup;
      q_push_data.css          = disp_ctl_ff[0];
      q_push_data.frame_end    = frame_end;
   end

   // Counter advances per graphics byte, wraps at frame end, holds otherwise
   always_comb begin
      byte_counter_in = byte_counter_ff;
      if (q_push && !unsup) begin
         byte_counter_in = frame_end ? 13'd0 : count_next[12:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         video_base_ff   <= VIDEO_BASE_RST;
         mem_mode_ff     <= 3'd0;
         disp_ctl_ff     <= 5'd0;
         byte_counter_ff <= 13'd0;
      end else begin
         video_base_ff   <= video_base_in;
         mem_mode_ff     <= mem_mode_in;
         disp_ctl_ff     <= disp_ctl_in;
         byte_counter_ff <= byte_counter_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bvpe_queue.sv
//------------------------------------------------------------------------------
// Bitmap video pixel expander descriptor queue
// Small FIFO between front and back; the head is visible without a pop.
//------------------------------------------------------------------------------
`default_nettype none

module bvpe_queue #(
   parameter int DEPTH = bvpe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  bvpe_pkg::desc_type  push_data,
   output logic                full,
   input  wire                 pop,
   output logic                head_valid,
   output bvpe_pkg::desc_type  head
);
   import bvpe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bvpe_back.sv
//------------------------------------------------------------------------------
// Bitmap video pixel expander back end
// Walks the head descriptor into the output register, one pixel per cycle while not stalled.
//------------------------------------------------------------------------------
`default_nettype none

module bvpe_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 head_valid,
   input  bvpe_pkg::desc_type  head,
   output logic                pop,
   bvpe_rsp_if.source          rsp
);
   import bvpe_pkg::*;

   logic [3:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [3:0] color_ff;
   logic [15:0] addr_ff;
   logic [3:0] gmode_ff;
   logic       unsup_ff, lob_ff, lof_ff;

   logic       fire;
   logic       dbl;
   logic [3:0] last_step;
   logic       is_last;
   logic [2:0] pix_idx;
   logic [1:0] pair;
   logic [3:0] color;

   // Pixel count per byte and which pixel this step shows
   always_comb begin
      dbl = (head.mode == GM_3R) || (head.mode == GM_6C);
      priority if (head.unsup) begin
         last_step = 4'd0;
      end else if (head.mode[0]) begin
         last_step = dbl ? 4'd15 : 4'd7;
      end else begin
         last_step = dbl ? 4'd7 : 4'd3;
      end
      is_last = (step_ff == last_step);
      pix_idx = dbl ? step_ff[3:1] : step_ff[2:0];
      pair    = head.video_byte[{~pix_idx[1:0], 1'b1} -: 2];
      priority if (head.unsup) begin
         color = 4'd0;
      end else if (head.mode[0]) begin
         color = head.video_byte[~pix_idx] ? palette_lookup({head.css, 2'b00}) : 4'd0;
      end else begin
         color = palette_lookup({head.css, pair});
      end
   end

   assign fire = head_valid && (!out_valid_ff || rsp.ready);
   assign pop  = fire && is_last;

   always_comb begin
      step_in = step_ff;
      if (fire) begin
         step_in = is_last ? 4'd0 : step_ff + 4'd1;
      end
      out_valid_in = fire || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (fire) begin
         color_ff <= color;
         addr_ff  <= head.byte_address;
         gmode_ff <= head.unsup ? GM_NONE : {1'b0, head.mode};
         unsup_ff <= head.unsup;
         lob_ff   <= is_last;
         lof_ff   <= is_last && head.frame_end && !head.unsup;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pixel_color   = color_ff;
   assign rsp.byte_address  = addr_ff;
   assign rsp.graphics_mode = gmode_ff;
   assign rsp.unsupported   = unsup_ff;
   assign rsp.last_of_byte  = lob_ff;
   assign rsp.last_of_frame = lof_ff;

endmodule

`default_nettype wire

// File: rtl/bitmap_video_pixel_expander.sv
// An accepted request goes into the queue; its first pixel then enters the output register.
// Throughput: one pixel per cycle out while the output is not stalled; a byte gives 4, 8
// or 16 pixels, one marker pixel in an unsupported mode, as the back end's step counter sets.
// A request is taken while the 2-entry queue has room, so the next byte waits there.
// Reset (synchronous, active high): queue and output empty, byte counter 0,
// video base 2, memory mode 0, display control 0.
//------------------------------------------------------------------------------
// Bitmap video pixel expander
// Expands video-memory bytes of bitmap graphics modes into palette pixels.
//------------------------------------------------------------------------------
`default_nettype none

module bitmap_video_pixel_expander #(
   parameter int QUEUE_DEPTH = bvpe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_wr_en,
   input  wire  [bvpe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [bvpe_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   bvpe_req_if.sink                          req_chan,
   bvpe_rsp_if.source                        rsp_chan
);
   import bvpe_pkg::*;

   logic     q_push, q_full, q_pop, q_head_valid;
   desc_type q_push_data, q_head;
   logic     req_ready;

   assign req_chan.ready = req_ready;

   bvpe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_chan.valid),
      .req_video_byte (req_chan.video_byte),
      .req_ready      (req_ready),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_push_data    (q_push_data)
   );

   bvpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   bvpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

// File: rtl/bvpe_checker.sv
//------------------------------------------------------------------------------
// Bitmap video pixel expander checker
// Port-level assertions on the pixel channel, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module bvpe_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire  [3:0]  rsp_pixel_color,
   input  wire  [15:0] rsp_byte_address,
   input  wire  [3:0]  rsp_graphics_mode,
   input  wire         rsp_unsupported,
   input  wire         rsp_last_of_byte,
   input  wire         rsp_last_of_frame
);
   import bvpe_pkg::*;

   // Unsupported modes give a single blank marker pixel
   a_unsup_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unsupported |->
         rsp_last_of_byte && !rsp_last_of_frame &&
         (rsp_graphics_mode == GM_NONE) && (rsp_pixel_color == 4'd0))
      else $error("unsupported request with bad fields");

   // Frame end only on the closing pixel of a graphics byte
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |->
         rsp_last_of_byte && !rsp_unsupported)
      else $error("last_of_frame without last_of_byte");

   // Graphics pixels carry a real mode code
   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_unsupported |-> rsp_graphics_mode != GM_NONE)
      else $error("graphics pixel with no mode");

   // Pixels within one byte share the byte address
   a_same_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_byte ##1 rsp_valid
         |-> $stable(rsp_byte_address))
      else $error("address changed inside a byte");

   // Stalled pixel holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pixel_color) && $stable(rsp_byte_address))
      else $error("stalled pixel changed");

endmodule

bind bitmap_video_pixel_expander bvpe_checker u_bvpe_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_pixel_color   (rsp_chan.pixel_color),
   .rsp_byte_address  (rsp_chan.byte_address),
   .rsp_graphics_mode (rsp_chan.graphics_mode),
   .rsp_unsupported   (rsp_chan.unsupported),
   .rsp_last_of_byte  (rsp_chan.last_of_byte),
   .rsp_last_of_frame (rsp_chan.last_of_frame)
);

`default_nettype wire
